/* rtl/core/fflia_pkg.sv */
// Package for the free-list ID allocator: pool sizing, field widths,
// request and status codes, payload structs and the controller state type.
// No dependencies.
`default_nettype none
package fflia_pkg;

  // Pool sizing
  localparam int SLOT_CAPACITY = 1024;
  localparam int PTR_W         = $clog2(SLOT_CAPACITY);
  localparam int CNT_W         = $clog2(SLOT_CAPACITY + 1);

  // Field widths
  localparam int ID_W     = 10;
  localparam int OFFSET_W = 26;
  localparam int LIVE_W   = 11;
  localparam int SIZE_W   = 16;

  // Request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_OFFSET  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET = 16'd4;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] slot_id;
  } in_data_t;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [OFFSET_W-1:0] byte_offset;
    logic [1:0]          status;
    logic [LIVE_W-1:0]   live_slots;
  } out_data_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/fflia_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fflia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/fifo_free_list_id_allocator_unit.sv */
// Slot ID allocator: FIFO free list in RAM, head/tail/count and live counters.
// Depends on fflia_pkg and fflia_ram.
// Results are registered and appear the cycle after accept; an allocate that
// pops the free list reads the head entry from RAM and passes through S_POP first.
// Throughput: one transaction per cycle while the result side is ready; no new
// request is accepted during S_POP after an allocate served from the free list.
// Reset (rst_n, synchronous): counters and pointers cleared, slot_size = 4;
// free-list RAM is not cleared, only written entries are ever read.
`default_nettype none
module fifo_free_list_id_allocator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire fflia_pkg::in_data_t          in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output fflia_pkg::out_data_t              out_data,
  input  wire logic                         cfg_we,
  input  wire logic [fflia_pkg::SIZE_W-1:0] cfg_wdata
);

  fflia_pkg::state_t state_r, state_nxt;

  logic [fflia_pkg::SIZE_W-1:0] slot_size_r;
  logic [fflia_pkg::PTR_W-1:0]  free_head_r, free_head_nxt;
  logic [fflia_pkg::PTR_W-1:0]  free_tail_r, free_tail_nxt;
  logic [fflia_pkg::CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [fflia_pkg::CNT_W-1:0]  live_count_r, live_count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  fflia_pkg::out_data_t out_data_r, out_data_nxt;

  logic                       accept;
  logic                       do_pop, do_push;
  logic [fflia_pkg::ID_W-1:0] ram_rdata;

  localparam logic [fflia_pkg::CNT_W-1:0] CAP_CNT  =
    fflia_pkg::CNT_W'(fflia_pkg::SLOT_CAPACITY);
  localparam logic [fflia_pkg::PTR_W-1:0] LAST_PTR =
    fflia_pkg::PTR_W'(fflia_pkg::SLOT_CAPACITY - 1);

  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Free-list storage
  fflia_ram #(
    .WIDTH (fflia_pkg::ID_W),
    .DEPTH (fflia_pkg::SLOT_CAPACITY)
  ) u_free_list (
    .clk   (clk),
    .we    (do_push),
    .waddr (free_tail_r),
    .wdata (in_data.slot_id),
    .re    (do_pop),
    .raddr (free_head_r),
    .rdata (ram_rdata)
  );

  // Request decode, counter and pointer updates
  always_comb begin
    do_pop         = 1'b0;
    do_push        = 1'b0;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    free_count_nxt = free_count_r;
    live_count_nxt = live_count_r;
    out_data_nxt   = out_data_r;
    if (accept) begin
      out_data_nxt.granted_id  = in_data.slot_id;
      out_data_nxt.byte_offset = '0;
      out_data_nxt.status      = fflia_pkg::ST_OK;
      case (in_data.req_type)
        fflia_pkg::REQ_ALLOC: begin
          if (live_count_r >= CAP_CNT) begin
            out_data_nxt.status     = fflia_pkg::ST_EXHAUSTED;
            out_data_nxt.granted_id = '0;
          end else begin
            if (free_count_r != '0) begin
              // ID comes from RAM next cycle
              do_pop         = 1'b1;
              free_head_nxt  = (free_head_r == LAST_PTR) ? '0 : free_head_r + 1'b1;
              free_count_nxt = free_count_r - 1'b1;
            end else begin
              out_data_nxt.granted_id = fflia_pkg::ID_W'(live_count_r);
            end
            live_count_nxt = live_count_r + 1'b1;
          end
        end
        fflia_pkg::REQ_RELEASE: begin
          if (live_count_r == '0) begin
            out_data_nxt.status = fflia_pkg::ST_UNDERFLOW;
          end else begin
            live_count_nxt = live_count_r - 1'b1;
            if (free_count_r < CAP_CNT) begin
              do_push        = 1'b1;
              free_tail_nxt  = (free_tail_r == LAST_PTR) ? '0 : free_tail_r + 1'b1;
              free_count_nxt = free_count_r + 1'b1;
            end
          end
        end
        fflia_pkg::REQ_OFFSET: begin
          out_data_nxt.byte_offset = fflia_pkg::OFFSET_W'(in_data.slot_id) *
                                     fflia_pkg::OFFSET_W'(slot_size_r);
        end
        default: begin
        end
      endcase
      out_data_nxt.live_slots = fflia_pkg::LIVE_W'(live_count_nxt);
    end else if (state_r == fflia_pkg::S_POP) begin
      out_data_nxt.granted_id = ram_rdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fflia_pkg::S_IDLE: if (do_pop) state_nxt = fflia_pkg::S_POP;
      fflia_pkg::S_POP:  state_nxt = fflia_pkg::S_IDLE;
      default:           state_nxt = fflia_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      fflia_pkg::S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (accept && !do_pop) out_valid_nxt = 1'b1;
      end
      fflia_pkg::S_POP: out_valid_nxt = 1'b1;
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fflia_pkg::S_IDLE;
      slot_size_r  <= fflia_pkg::SLOT_SIZE_RESET;
      free_head_r  <= '0;
      free_tail_r  <= '0;
      free_count_r <= '0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      free_count_r <= free_count_nxt;
      live_count_r <= live_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) slot_size_r <= cfg_wdata;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
